FILE: src/lsrc_pkg.sv
// ---------------------------------------------------------------------------
// lsrc_pkg
// Shared widths, register indexes and corner side-band type for the light
// screen rectangle culling core.
// ---------------------------------------------------------------------------
package lsrc_pkg;

    localparam int ENTRY_W    = 32;              // Q15.16 matrix entry
    localparam int COORD_W    = 32;              // Q15.16 corner coordinate
    localparam int RANGE_W    = 31;
    localparam int PROD_W     = ENTRY_W + COORD_W;
    localparam int FRAC_W     = 16;
    localparam int ROW_W      = 50;              // row value, Q.16
    localparam int NDC_SHIFT  = 14;
    localparam int NUM_W      = 64;              // |row| << 14
    localparam int QUO_W      = 31;              // quotient magnitude bits
    localparam int DIV_LAT    = QUO_W + 1;
    localparam int NDC_W      = 32;
    localparam int OUT_W      = 16;
    localparam int AREA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CORNER_W   = 3;
    localparam int NUM_ROWS   = 3;
    localparam int NUM_AXES   = 3;

    localparam logic signed [NDC_W-1:0] NDC_ONE   = 32'sd16384;
    localparam logic signed [NDC_W-1:0] NDC_LIMIT = 32'sd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X_01 = 3'd0,
        CFG_ROW_X_23 = 3'd1,
        CFG_ROW_Y_01 = 3'd2,
        CFG_ROW_Y_23 = 3'd3,
        CFG_ROW_W_01 = 3'd4,
        CFG_ROW_W_23 = 3'd5,
        CFG_AREA_THR = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic dir;
        logic behind;
        logic neg_x;
        logic neg_y;
    } corner_meta_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W:0] v
    );
        logic signed [COORD_W-1:0] res;
        if (v[COORD_W] != v[COORD_W-1])
        begin
            res = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: src/lsrc_div.sv
// ---------------------------------------------------------------------------
// lsrc_div
// Pipelined restoring divider, one quotient bit per stage. Flags a quotient
// of 2^QUO_W or more as overflow.
// ---------------------------------------------------------------------------
module lsrc_div
    import lsrc_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [NUM_W-1:0]   num,
    input  logic [ROW_W-1:0]   den,
    output logic [QUO_W-1:0]   quo,
    output logic               ovf
);

    logic [ROW_W-1:0] rem_reg  [0:QUO_W];
    logic [ROW_W-1:0] den_reg  [0:QUO_W];
    logic [QUO_W-1:0] nlow_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg  [0:QUO_W];
    logic             ovf_reg  [0:QUO_W];

    logic [ROW_W-1:0] rem_next [0:QUO_W-1];
    logic [QUO_W-1:0] quo_next [0:QUO_W-1];

    logic [NUM_W-QUO_W-1:0] num_hi;

    assign num_hi = num[NUM_W-1:QUO_W];

    always_comb
    begin
        logic [ROW_W:0] trial;
        logic           ge;
        for (int s = 0; s < QUO_W; s++)
        begin
            trial = {rem_reg[s], nlow_reg[s][QUO_W-1-s]};
            ge    = (trial >= {1'b0, den_reg[s]});
            rem_next[s] = ge ? ROW_W'(trial - {1'b0, den_reg[s]}) : ROW_W'(trial);
            quo_next[s] = quo_reg[s];
            quo_next[s][QUO_W-1-s] = ge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0]  <= (ROW_W'(num_hi) >= den);
            rem_reg[0]  <= ROW_W'(num_hi);
            nlow_reg[0] <= num[QUO_W-1:0];
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            for (int s = 0; s < QUO_W; s++)
            begin
                rem_reg[s+1]  <= rem_next[s];
                quo_reg[s+1]  <= quo_next[s];
                nlow_reg[s+1] <= nlow_reg[s];
                den_reg[s+1]  <= den_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
            end
        end
    end

    assign quo = quo_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule

FILE: src/light_screen_rect_cull_core.sv
// A new light is accepted on the last corner of the one before, so lights
// overlap; the corner sequencer issues one cube corner per cycle, unless a
// stall holds it, into the transform, divide and min/max pipeline.
// Any output stall freezes the whole pipeline in place.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the default
// matrix rows and area threshold.
// ---------------------------------------------------------------------------
// light_screen_rect_cull_core
// Projects the eight corners of a light's bounding cube, builds its NDC rectangle,
// culls it off screen or below an area threshold; directional lights pass full screen.
// ---------------------------------------------------------------------------
module light_screen_rect_cull_core
    import lsrc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_W-1:0]    center_x,
    input  logic signed [COORD_W-1:0]    center_y,
    input  logic signed [COORD_W-1:0]    center_z,
    input  logic [RANGE_W-1:0]           light_range,
    input  logic                         is_directional,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         visible,
    output logic                         behind_eye,
    output logic signed [OUT_W-1:0]      min_x,
    output logic signed [OUT_W-1:0]      min_y,
    output logic signed [OUT_W-1:0]      max_x,
    output logic signed [OUT_W-1:0]      max_y
);

    // configuration
    logic [CFG_DATA_W-1:0] row_x_01_reg, row_x_23_reg, row_y_01_reg;
    logic [CFG_DATA_W-1:0] row_y_23_reg, row_w_01_reg, row_w_23_reg;
    logic [AREA_W-1:0]     area_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_01_reg <= 64'h0000_0001_0000_0000;
            row_x_23_reg <= '0;
            row_y_01_reg <= 64'h0001_0000_0000_0000;
            row_y_23_reg <= '0;
            row_w_01_reg <= '0;
            row_w_23_reg <= 64'h0001_0000_0000_0000;
            area_thr_reg <= 32'd74565;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ROW_X_01: row_x_01_reg <= cfg_data;
                CFG_ROW_X_23: row_x_23_reg <= cfg_data;
                CFG_ROW_Y_01: row_y_01_reg <= cfg_data;
                CFG_ROW_Y_23: row_y_23_reg <= cfg_data;
                CFG_ROW_W_01: row_w_01_reg <= cfg_data;
                CFG_ROW_W_23: row_w_23_reg <= cfg_data;
                CFG_AREA_THR: area_thr_reg <= cfg_data[AREA_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [ENTRY_W-1:0] ent [0:NUM_ROWS-1][0:NUM_AXES];

    always_comb
    begin
        ent[0][0] = row_x_01_reg[31:0];  ent[0][1] = row_x_01_reg[63:32];
        ent[0][2] = row_x_23_reg[31:0];  ent[0][3] = row_x_23_reg[63:32];
        ent[1][0] = row_y_01_reg[31:0];  ent[1][1] = row_y_01_reg[63:32];
        ent[1][2] = row_y_23_reg[31:0];  ent[1][3] = row_y_23_reg[63:32];
        ent[2][0] = row_w_01_reg[31:0];  ent[2][1] = row_w_01_reg[63:32];
        ent[2][2] = row_w_23_reg[31:0];  ent[2][3] = row_w_23_reg[63:32];
    end

    // global advance: hold everything while a result waits
    logic en;
    assign en = !out_valid || out_ready;

    // corner sequencer
    logic                       busy_reg;
    logic [CORNER_W-1:0]        corner_cnt_reg;
    logic signed [COORD_W-1:0]  item_c_reg [0:NUM_AXES-1];
    logic [RANGE_W-1:0]         item_r_reg;
    logic                       item_dir_reg;
    logic                       last_corner;
    logic                       in_xfer;

    assign last_corner = (corner_cnt_reg == {CORNER_W{1'b1}});
    assign in_ready    = en && (!busy_reg || last_corner);
    assign in_xfer     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            corner_cnt_reg <= '0;
        end
        else if (en)
        begin
            if (in_xfer)
            begin
                busy_reg       <= 1'b1;
                corner_cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg       <= !last_corner;
                corner_cnt_reg <= corner_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_c_reg[0] <= center_x;
            item_c_reg[1] <= center_y;
            item_c_reg[2] <= center_z;
            item_r_reg    <= light_range;
            item_dir_reg  <= is_directional;
        end
    end

    // stage P: corner coordinates
    logic signed [COORD_W-1:0] p_reg [0:NUM_AXES-1];
    logic signed [COORD_W-1:0] p_next [0:NUM_AXES-1];
    corner_meta_t              meta_p_reg;

    always_comb
    begin
        logic signed [COORD_W:0] c_ext;
        logic signed [COORD_W:0] r_ext;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            c_ext = {item_c_reg[i][COORD_W-1], item_c_reg[i]};
            r_ext = {2'b00, item_r_reg};
            p_next[i] = sat_coord(corner_cnt_reg[i] ? c_ext + r_ext : c_ext - r_ext);
        end
    end

    // stage M: products, stage R: row sums
    logic signed [PROD_W-1:0] prod_reg [0:NUM_ROWS-1][0:NUM_AXES-1];
    corner_meta_t             meta_m_reg;
    logic signed [ROW_W-1:0]  row_reg [0:NUM_ROWS-1];
    logic signed [ROW_W-1:0]  row_next [0:NUM_ROWS-1];
    corner_meta_t             meta_r_reg;

    always_comb
    begin
        logic signed [PROD_W-1:0] term;
        for (int j = 0; j < NUM_ROWS; j++)
        begin
            row_next[j] = ROW_W'(ent[j][NUM_AXES]);
            for (int i = 0; i < NUM_AXES; i++)
            begin
                term = prod_reg[j][i] >>> FRAC_W;
                row_next[j] = row_next[j] + ROW_W'(term);
            end
        end
    end

    // stage D: divider operands
    logic [NUM_W-1:0]  num_x_reg, num_y_reg;
    logic [ROW_W-1:0]  den_reg;
    corner_meta_t      meta_d_reg;
    logic              behind_d;
    logic [ROW_W-1:0]  mag_x, mag_y;

    assign behind_d = (row_reg[2] <= 0);
    assign mag_x    = row_reg[0][ROW_W-1] ? ROW_W'(-row_reg[0]) : row_reg[0];
    assign mag_y    = row_reg[1][ROW_W-1] ? ROW_W'(-row_reg[1]) : row_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_p_reg <= '0;
            meta_m_reg <= '0;
            meta_r_reg <= '0;
            meta_d_reg <= '0;
        end
        else if (en)
        begin
            meta_p_reg <= '{valid: busy_reg, first: (corner_cnt_reg == '0),
                            last: last_corner, dir: item_dir_reg,
                            behind: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
            meta_m_reg <= meta_p_reg;
            meta_r_reg <= meta_m_reg;
            meta_d_reg <= '{valid: meta_r_reg.valid, first: meta_r_reg.first,
                            last: meta_r_reg.last, dir: meta_r_reg.dir,
                            behind: behind_d, neg_x: row_reg[0][ROW_W-1],
                            neg_y: row_reg[1][ROW_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
            for (int j = 0; j < NUM_ROWS; j++)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    prod_reg[j][i] <= ent[j][i] * p_reg[i];
                end
            end
            row_reg   <= row_next;
            num_x_reg <= {mag_x, {NDC_SHIFT{1'b0}}};
            num_y_reg <= {mag_y, {NDC_SHIFT{1'b0}}};
            den_reg   <= behind_d ? ROW_W'(1) : row_reg[2];
        end
    end

    // divide x and y by w
    logic [QUO_W-1:0] quo_x, quo_y;
    logic             ovf_x, ovf_y;

    lsrc_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (num_x_reg),
        .den (den_reg),
        .quo (quo_x),
        .ovf (ovf_x)
    );

    lsrc_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (num_y_reg),
        .den (den_reg),
        .quo (quo_y),
        .ovf (ovf_y)
    );

    corner_meta_t meta_q_reg [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_LAT; s++)
            begin
                meta_q_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            meta_q_reg[0] <= meta_d_reg;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                meta_q_reg[s] <= meta_q_reg[s-1];
            end
        end
    end

    // stage N: signed, saturated NDC
    logic signed [NDC_W-1:0] nx_reg, ny_reg, nx_next, ny_next;
    corner_meta_t            meta_n_reg;
    corner_meta_t            meta_q_out;
    logic [NDC_W-1:0]        qx_sat, qy_sat;

    assign meta_q_out = meta_q_reg[DIV_LAT-1];
    assign qx_sat  = (ovf_x || NDC_W'(quo_x) > NDC_LIMIT) ? NDC_LIMIT : NDC_W'(quo_x);
    assign qy_sat  = (ovf_y || NDC_W'(quo_y) > NDC_LIMIT) ? NDC_LIMIT : NDC_W'(quo_y);
    assign nx_next = meta_q_out.neg_x ? -$signed(qx_sat) : $signed(qx_sat);
    assign ny_next = meta_q_out.neg_y ? -$signed(qy_sat) : $signed(qy_sat);

    // min/max accumulation over the eight corners
    logic signed [NDC_W-1:0] acc_lo_x_reg, acc_lo_y_reg, acc_hi_x_reg, acc_hi_y_reg;
    logic                    acc_beh_reg;
    logic signed [NDC_W-1:0] lo_x_next, lo_y_next, hi_x_next, hi_y_next;
    logic                    beh_next;

    always_comb
    begin
        if (meta_n_reg.first)
        begin
            lo_x_next = nx_reg;
            lo_y_next = ny_reg;
            hi_x_next = nx_reg;
            hi_y_next = ny_reg;
            beh_next  = meta_n_reg.behind;
        end
        else
        begin
            lo_x_next = (nx_reg < acc_lo_x_reg) ? nx_reg : acc_lo_x_reg;
            lo_y_next = (ny_reg < acc_lo_y_reg) ? ny_reg : acc_lo_y_reg;
            hi_x_next = (nx_reg > acc_hi_x_reg) ? nx_reg : acc_hi_x_reg;
            hi_y_next = (ny_reg > acc_hi_y_reg) ? ny_reg : acc_hi_y_reg;
            beh_next  = acc_beh_reg || meta_n_reg.behind;
        end
    end

    // finishing stages
    logic                    f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic signed [NDC_W-1:0] f1_lo_x_reg, f1_lo_y_reg, f1_hi_x_reg, f1_hi_y_reg;
    logic signed [NDC_W-1:0] f2_lo_x_reg, f2_lo_y_reg, f2_hi_x_reg, f2_hi_y_reg;
    logic signed [NDC_W-1:0] f3_lo_x_reg, f3_lo_y_reg, f3_hi_x_reg, f3_hi_y_reg;
    logic                    f1_beh_reg, f2_beh_reg, f3_beh_reg;
    logic                    f1_dir_reg, f2_dir_reg, f3_dir_reg;
    logic                    f2_off_reg, f3_off_reg;
    logic [NDC_W-1:0]        f2_dx_reg, f2_dy_reg;
    logic [2*NDC_W-1:0]      f3_prod_reg;

    logic                    off_next;
    logic [AREA_W-1:0]       area;
    logic                    vis_next;
    logic signed [NDC_W-1:0] clip_lo_x, clip_lo_y, clip_hi_x, clip_hi_y;

    assign off_next = (f1_lo_x_reg > NDC_ONE) || (f1_lo_y_reg > NDC_ONE)
                   || (f1_hi_x_reg < -NDC_ONE) || (f1_hi_y_reg < -NDC_ONE);
    assign area = (f3_prod_reg > 64'h3FFF_FFFF) ? {AREA_W{1'b1}}
                                                : {f3_prod_reg[AREA_W-3:0], 2'b00};
    assign vis_next  = f3_dir_reg || (!f3_off_reg && area >= area_thr_reg);
    assign clip_lo_x = (f3_lo_x_reg < -NDC_ONE) ? -NDC_ONE : f3_lo_x_reg;
    assign clip_lo_y = (f3_lo_y_reg < -NDC_ONE) ? -NDC_ONE : f3_lo_y_reg;
    assign clip_hi_x = (f3_hi_x_reg > NDC_ONE) ? NDC_ONE : f3_hi_x_reg;
    assign clip_hi_y = (f3_hi_y_reg > NDC_ONE) ? NDC_ONE : f3_hi_y_reg;

    logic                    out_valid_reg, visible_reg, behind_eye_reg;
    logic signed [OUT_W-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_n_reg    <= '0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            meta_n_reg    <= meta_q_out;
            f1_valid_reg  <= meta_n_reg.valid && meta_n_reg.last;
            f2_valid_reg  <= f1_valid_reg;
            f3_valid_reg  <= f2_valid_reg;
            out_valid_reg <= f3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            if (meta_n_reg.valid)
            begin
                acc_lo_x_reg <= lo_x_next;
                acc_lo_y_reg <= lo_y_next;
                acc_hi_x_reg <= hi_x_next;
                acc_hi_y_reg <= hi_y_next;
                acc_beh_reg  <= beh_next;
            end
            // a corner behind the eye forces the full screen
            f1_lo_x_reg <= beh_next ? -NDC_ONE : lo_x_next;
            f1_lo_y_reg <= beh_next ? -NDC_ONE : lo_y_next;
            f1_hi_x_reg <= beh_next ? NDC_ONE : hi_x_next;
            f1_hi_y_reg <= beh_next ? NDC_ONE : hi_y_next;
            f1_beh_reg  <= beh_next;
            f1_dir_reg  <= meta_n_reg.dir;

            f2_lo_x_reg <= f1_lo_x_reg;
            f2_lo_y_reg <= f1_lo_y_reg;
            f2_hi_x_reg <= f1_hi_x_reg;
            f2_hi_y_reg <= f1_hi_y_reg;
            f2_beh_reg  <= f1_beh_reg;
            f2_dir_reg  <= f1_dir_reg;
            f2_off_reg  <= off_next;
            f2_dx_reg   <= NDC_W'(f1_hi_x_reg - f1_lo_x_reg);
            f2_dy_reg   <= NDC_W'(f1_hi_y_reg - f1_lo_y_reg);

            f3_lo_x_reg <= f2_lo_x_reg;
            f3_lo_y_reg <= f2_lo_y_reg;
            f3_hi_x_reg <= f2_hi_x_reg;
            f3_hi_y_reg <= f2_hi_y_reg;
            f3_beh_reg  <= f2_beh_reg;
            f3_dir_reg  <= f2_dir_reg;
            f3_off_reg  <= f2_off_reg;
            f3_prod_reg <= f2_dx_reg * f2_dy_reg;

            visible_reg    <= vis_next;
            behind_eye_reg <= f3_beh_reg && !f3_dir_reg;
            if (f3_dir_reg)
            begin
                min_x_reg <= OUT_W'(-NDC_ONE);
                min_y_reg <= OUT_W'(-NDC_ONE);
                max_x_reg <= OUT_W'(NDC_ONE);
                max_y_reg <= OUT_W'(NDC_ONE);
            end
            else if (vis_next)
            begin
                min_x_reg <= clip_lo_x[OUT_W-1:0];
                min_y_reg <= clip_lo_y[OUT_W-1:0];
                max_x_reg <= clip_hi_x[OUT_W-1:0];
                max_y_reg <= clip_hi_y[OUT_W-1:0];
            end
            else
            begin
                min_x_reg <= '0;
                min_y_reg <= '0;
                max_x_reg <= '0;
                max_y_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign visible    = visible_reg;
    assign behind_eye = behind_eye_reg;
    assign min_x      = min_x_reg;
    assign min_y      = min_y_reg;
    assign max_x      = max_x_reg;
    assign max_y      = max_y_reg;

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> busy_reg)
        else $error("sequencer not busy after input transfer");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !en |=> $stable(corner_cnt_reg))
        else $error("corner counter moved during stall");

    a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> min_x == 0 && min_y == 0 && max_x == 0 && max_y == 0)
        else $error("culled light has non-zero extent");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> min_x <= max_x && min_y <= max_y)
        else $error("visible extent inverted");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        f1_valid_reg && en |=> !f1_valid_reg)
        else $error("two results in consecutive cycles");

endmodule
